// File: rtl/assert_macros.svh
// assertion helper macros shared by the planner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TBBP_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define TBBP_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/tbbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbp_pkg
// shared types, codes and reset values for the token budget batch planner
// ----------------------------------------------------------------------------
package tbbp_pkg;

    // slot count default
    localparam int SLOT_COUNT_DEF = 64;

    // queue depth defaults
    localparam int MID_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    // field widths
    localparam int BUDGET_W = 12;
    localparam int SLOT_W   = 6;
    localparam int POS_W    = 16;
    localparam int TOKEN_W  = 18;
    localparam int DIST_W   = 7;
    localparam int CFG_IDX_W = 2;

    // action codes of an input word
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_DECODE  = 2'd1;
    localparam logic [1:0] ACT_PREFILL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFILL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK   = 2'd3;

    // configuration reset values
    localparam logic [BUDGET_W-1:0] TOTAL_RST   = 12'd256;
    localparam logic [BUDGET_W-1:0] DECODE_RST  = 12'd64;
    localparam logic [BUDGET_W-1:0] PREFILL_RST = 12'd192;
    localparam logic [BUDGET_W-1:0] CHUNK_RST   = 12'd0;

    // input word
    typedef struct packed {
        logic [1:0]          action;
        logic [SLOT_W-1:0]   slot_id;
        logic                slot_valid;
        logic [POS_W-1:0]    prompt_length;
        logic [POS_W-1:0]    generated_count;
        logic [TOKEN_W-1:0]  last_token;
        logic [POS_W-1:0]    prefill_position;
    } item_t;

    // result word
    typedef struct packed {
        logic [SLOT_W-1:0]   out_slot;
        logic                is_prefill;
        logic [POS_W-1:0]    start_position;
        logic [BUDGET_W-1:0] token_count;
        logic [TOKEN_W-1:0]  token_id;
        logic                want_logits;
        logic [DIST_W-1:0]   distinct_slots;
        logic [BUDGET_W-1:0] decode_total;
        logic [BUDGET_W-1:0] prefill_total;
    } result_t;

    // classified work kind between front and back
    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_DECODE  = 2'd1,
        KIND_PREFILL = 2'd2
    } kind_t;

    // classified word held in the middle queue
    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [POS_W-1:0]    start;
        logic [POS_W-1:0]    prompt_left;
        logic [TOKEN_W-1:0]  token;
    } mid_t;

    // configuration bundle
    typedef struct packed {
        logic [BUDGET_W-1:0] total_budget;
        logic [BUDGET_W-1:0] decode_budget;
        logic [BUDGET_W-1:0] prefill_budget;
        logic [BUDGET_W-1:0] chunk_size;
    } cfg_t;

endpackage

// File: rtl/token_budget_batch_planner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_budget_batch_planner_top
// per-tick token budget planner: front classifier, middle queue, budget
// back end and result queue, plus the configuration registers
// ----------------------------------------------------------------------------
// throughput: one input word per cycle, sustained, as long as results are popped
// path: a contributing word is stored in the middle queue, settled by the budget back end
//   and stored in the result queue, from which it can be popped; a full result queue stalls it
// the budget back end settles each word combinationally against the running state
// reset: asynchronous, active low; clears queues and tick state, budgets left at
//   zero, configuration back to its default values
// ----------------------------------------------------------------------------
module token_budget_batch_planner_top #(
    parameter int SLOT_COUNT = tbbp_pkg::SLOT_COUNT_DEF,
    parameter int MID_DEPTH  = tbbp_pkg::MID_DEPTH_DEF,
    parameter int RES_DEPTH  = tbbp_pkg::RES_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  tbbp_pkg::item_t                   item,
    output logic                              empty,
    input  logic                              pop,
    output tbbp_pkg::result_t                 result,
    input  logic                              wr_en,
    input  logic [tbbp_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [tbbp_pkg::BUDGET_W-1:0]     wr_data
);

    tbbp_pkg::cfg_t    cfg_reg;
    logic              keep;
    tbbp_pkg::mid_t    work;
    logic              mid_full;
    logic              mid_empty;
    logic              mid_pop;
    logic [$bits(tbbp_pkg::mid_t)-1:0]    mid_bits;
    logic              res_full;
    logic              res_push;
    tbbp_pkg::result_t res_word;
    logic [$bits(tbbp_pkg::result_t)-1:0] res_bits;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_budget   <= tbbp_pkg::TOTAL_RST;
            cfg_reg.decode_budget  <= tbbp_pkg::DECODE_RST;
            cfg_reg.prefill_budget <= tbbp_pkg::PREFILL_RST;
            cfg_reg.chunk_size     <= tbbp_pkg::CHUNK_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                tbbp_pkg::CFG_TOTAL:   cfg_reg.total_budget   <= wr_data;
                tbbp_pkg::CFG_DECODE:  cfg_reg.decode_budget  <= wr_data;
                tbbp_pkg::CFG_PREFILL: cfg_reg.prefill_budget <= wr_data;
                tbbp_pkg::CFG_CHUNK:   cfg_reg.chunk_size     <= wr_data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: classify every accepted word
    tbbp_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .item (item),
        .keep (keep),
        .work (work)
    );

    assign full = mid_full;

    // middle queue between classifier and budget logic
    tbbp_fifo #(
        .WIDTH ($bits(tbbp_pkg::mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && keep),
        .push_data (work),
        .full      (mid_full),
        .pop       (mid_pop),
        .pop_data  (mid_bits),
        .empty     (mid_empty)
    );

    // back: budgets and running totals
    tbbp_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid       (tbbp_pkg::mid_t'(mid_bits)),
        .mid_pop   (mid_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_word)
    );

    // result queue toward the consumer
    tbbp_fifo #(
        .WIDTH ($bits(tbbp_pkg::result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_word),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_bits),
        .empty     (empty)
    );

    assign result = tbbp_pkg::result_t'(res_bits);

endmodule

// File: rtl/tbbp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbp_fifo
// small register queue with full/empty flags, used between pipeline parts
// ----------------------------------------------------------------------------
module tbbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = data_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/tbbp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbp_front
// classifies input words, drops those that can never contribute and
// precomputes the state-free parts of decode and prefill work
// ----------------------------------------------------------------------------
module tbbp_front #(
    parameter int SLOT_COUNT = tbbp_pkg::SLOT_COUNT_DEF
) (
    input  tbbp_pkg::item_t item,
    output logic            keep,
    output tbbp_pkg::mid_t  work
);

    logic                          slot_ok;
    logic [tbbp_pkg::POS_W:0]      pos_sum;
    logic [tbbp_pkg::POS_W:0]      pos_raw;
    logic [tbbp_pkg::POS_W-1:0]    dec_pos;
    logic                          gen_nonzero;
    logic                          prompt_open;

    // slot must exist and be in range
    assign slot_ok = item.slot_valid &&
                     ({1'b0, item.slot_id} < (tbbp_pkg::SLOT_W + 1)'(SLOT_COUNT));

    // decode position: prompt plus generated minus one, saturated
    assign pos_sum = {1'b0, item.prompt_length} + {1'b0, item.generated_count};
    assign pos_raw = pos_sum - (tbbp_pkg::POS_W + 1)'(1);
    assign dec_pos = pos_raw[tbbp_pkg::POS_W] ? '1 : pos_raw[tbbp_pkg::POS_W-1:0];

    assign gen_nonzero = (item.generated_count != '0);
    assign prompt_open = (item.prefill_position < item.prompt_length);

    // classification
    always_comb
    begin
        keep             = 1'b0;
        work.kind        = tbbp_pkg::KIND_START;
        work.slot        = item.slot_id;
        work.start       = item.prefill_position;
        work.prompt_left = item.prompt_length - item.prefill_position;
        work.token       = item.last_token;
        case (item.action)
            tbbp_pkg::ACT_START:
            begin
                keep      = 1'b1;
                work.kind = tbbp_pkg::KIND_START;
            end
            tbbp_pkg::ACT_DECODE:
            begin
                keep       = slot_ok && gen_nonzero;
                work.kind  = tbbp_pkg::KIND_DECODE;
                work.start = dec_pos;
            end
            tbbp_pkg::ACT_PREFILL:
            begin
                keep      = slot_ok && prompt_open;
                work.kind = tbbp_pkg::KIND_PREFILL;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/tbbp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbbp_back
// applies classified work against the per-tick budgets, tracks distinct
// slots and running totals, and forms result words
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbbp_back #(
    parameter int SLOT_COUNT = tbbp_pkg::SLOT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tbbp_pkg::cfg_t    cfg,
    input  logic              mid_empty,
    input  tbbp_pkg::mid_t    mid,
    output logic              mid_pop,
    input  logic              res_full,
    output logic              res_push,
    output tbbp_pkg::result_t res
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int BW    = tbbp_pkg::BUDGET_W;

    logic [BW-1:0]         dec_left_reg, dec_left_next;
    logic [BW-1:0]         pre_left_reg, pre_left_next;
    logic [BW-1:0]         dec_sum_reg, dec_sum_next;
    logic [BW-1:0]         pre_sum_reg, pre_sum_next;
    logic [SLOT_COUNT-1:0] seen_map_reg, seen_map_next;
    logic [CNT_W-1:0]      seen_cnt_reg, seen_cnt_next;

    logic [BW-1:0]         pre_limit;
    logic                  prompt_fits;
    logic [BW-1:0]         pre_count;
    logic                  emit;
    logic                  mark;
    logic [IDX_W-1:0]      slot_idx;
    logic                  is_pre;

    // prefill run length: min of chunk, budget left and prompt left
    always_comb
    begin
        pre_limit = pre_left_reg;
        if (cfg.chunk_size != '0 && cfg.chunk_size < pre_left_reg)
        begin
            pre_limit = cfg.chunk_size;
        end
    end

    assign prompt_fits = (mid.prompt_left <= {{(tbbp_pkg::POS_W - BW){1'b0}}, pre_limit});
    assign pre_count   = prompt_fits ? mid.prompt_left[BW-1:0] : pre_limit;
    assign slot_idx    = mid.slot[IDX_W-1:0];
    assign is_pre      = (mid.kind == tbbp_pkg::KIND_PREFILL);

    // take one word whenever the result queue has room
    assign mid_pop  = !mid_empty && !res_full;
    assign res_push = mid_pop && emit;

    // tick state update
    always_comb
    begin
        dec_left_next = dec_left_reg;
        pre_left_next = pre_left_reg;
        dec_sum_next  = dec_sum_reg;
        pre_sum_next  = pre_sum_reg;
        seen_map_next = seen_map_reg;
        seen_cnt_next = seen_cnt_reg;
        emit          = 1'b0;
        mark          = 1'b0;
        if (mid_pop)
        begin
            case (mid.kind)
                tbbp_pkg::KIND_START:
                begin
                    dec_left_next = (cfg.total_budget == '0) ? '0 : cfg.decode_budget;
                    pre_left_next = (cfg.total_budget == '0) ? '0 : cfg.prefill_budget;
                    dec_sum_next  = '0;
                    pre_sum_next  = '0;
                    seen_map_next = '0;
                    seen_cnt_next = '0;
                end
                tbbp_pkg::KIND_DECODE:
                begin
                    if (dec_left_reg != '0)
                    begin
                        emit          = 1'b1;
                        mark          = 1'b1;
                        dec_left_next = dec_left_reg - BW'(1);
                        dec_sum_next  = dec_sum_reg + BW'(1);
                    end
                end
                tbbp_pkg::KIND_PREFILL:
                begin
                    if (pre_left_reg != '0)
                    begin
                        emit          = 1'b1;
                        mark          = 1'b1;
                        pre_left_next = pre_left_reg - pre_count;
                        pre_sum_next  = pre_sum_reg + pre_count;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        // first contribution of a slot this tick
        if (mark && !seen_map_reg[slot_idx])
        begin
            seen_map_next[slot_idx] = 1'b1;
            seen_cnt_next           = seen_cnt_reg + CNT_W'(1);
        end
    end

    // result word with running values after this contribution
    always_comb
    begin
        res.out_slot       = mid.slot;
        res.is_prefill     = is_pre;
        res.start_position = mid.start;
        res.token_count    = is_pre ? pre_count : BW'(1);
        res.token_id       = is_pre ? '0 : mid.token;
        res.want_logits    = is_pre ? prompt_fits : 1'b1;
        res.distinct_slots = tbbp_pkg::DIST_W'(seen_cnt_next);
        res.decode_total   = dec_sum_next;
        res.prefill_total  = pre_sum_next;
    end

    // tick state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_left_reg <= '0;
            pre_left_reg <= '0;
            dec_sum_reg  <= '0;
            pre_sum_reg  <= '0;
            seen_map_reg <= '0;
            seen_cnt_reg <= '0;
        end
        else
        begin
            dec_left_reg <= dec_left_next;
            pre_left_reg <= pre_left_next;
            dec_sum_reg  <= dec_sum_next;
            pre_sum_reg  <= pre_sum_next;
            seen_map_reg <= seen_map_next;
            seen_cnt_reg <= seen_cnt_next;
        end
    end

    // checks
    `TBBP_ASSERT_IMP(a_seen_count, clk, rst_n, 1'b1, $countones(seen_map_reg) == seen_cnt_reg, "seen count disagrees with seen map")
    `TBBP_ASSERT_NXT(a_decode_spend, clk, rst_n, res_push && !is_pre, dec_left_reg == $past(dec_left_reg) - BW'(1), "decode budget not spent by one")
    `TBBP_ASSERT_IMP(a_prefill_bound, clk, rst_n, res_push && is_pre, pre_count != '0 && pre_count <= pre_left_reg, "prefill run outside budget")
    `TBBP_ASSERT_IMP(a_no_overflow, clk, rst_n, res_push, !res_full, "result written into full queue")

endmodule
